FILE: design/co2f_pkg.sv
// Shared types and constants for the CO2 sensor UART command framer.
package co2f_pkg;

    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned BODY_BYTES  = FRAME_BYTES - 2;
    localparam int unsigned IDX_W       = 4;

    // Input item kinds
    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_ZERO  = 3'd1;
    localparam logic [2:0] KIND_SPAN  = 3'd2;
    localparam logic [2:0] KIND_RANGE = 3'd3;
    localparam logic [2:0] KIND_AUTO  = 3'd4;
    localparam logic [2:0] KIND_RX    = 3'd5;

    // Result kinds
    localparam logic OUT_TX      = 1'b0;
    localparam logic OUT_READING = 1'b1;

    // Reading status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd2;

    // Frame bytes and opcodes
    localparam logic [7:0] FRAME_START = 8'hFF;
    localparam logic [7:0] OP_READ     = 8'h86;
    localparam logic [7:0] OP_ZERO     = 8'h87;
    localparam logic [7:0] OP_SPAN     = 8'h88;
    localparam logic [7:0] OP_RANGE    = 8'h99;
    localparam logic [7:0] OP_AUTO     = 8'h79;
    localparam logic [7:0] AUTO_ON_ARG = 8'hA0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] span_ppm;
        logic [31:0] range_word;
        logic        auto_on;
        logic [7:0]  rx_byte;
    } in_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] ppm;
        logic [1:0]  status;
    } out_t;

    // One queued job: a whole command frame or one reading
    typedef struct packed {
        logic                        is_reading;
        logic [BODY_BYTES-1:0][7:0]  body;   // frame bytes 1..7
        logic [7:0]                  check;
        logic [15:0]                 ppm;
        logic [1:0]                  status;
    } job_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic empty;
        job_t head;
    } q_head_t;

endpackage

FILE: design/co2f_front.sv
// Front end: accepts items, builds command frames, collects reply bytes.
module co2f_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  co2f_pkg::in_t        s_data,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_data,
    input  logic                 q_full,
    output logic                 q_push,
    output co2f_pkg::job_t       q_job
);

    logic [7:0]                  addr_reg;
    logic [co2f_pkg::IDX_W-1:0]  rx_index_reg, rx_index_next;
    logic [7:0]                  rx_header_reg, rx_header_next;
    logic [7:0]                  rx_high_reg, rx_high_next;
    logic [7:0]                  rx_low_reg, rx_low_next;
    logic [7:0]                  rx_sum_reg, rx_sum_next;
    logic                        accept;
    logic [7:0]                  opcode;
    logic [4:0][7:0]             args;
    logic [7:0]                  body_sum;
    logic [7:0]                  expect_sum;
    logic                        last_rx;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign last_rx = (rx_index_reg == co2f_pkg::IDX_W'(co2f_pkg::FRAME_BYTES - 1));

    // frame contents per command kind
    always_comb begin
        opcode = co2f_pkg::OP_READ;
        args   = '0;
        unique case (s_data.kind)
            co2f_pkg::KIND_READ:  opcode = co2f_pkg::OP_READ;
            co2f_pkg::KIND_ZERO:  opcode = co2f_pkg::OP_ZERO;
            co2f_pkg::KIND_SPAN: begin
                opcode  = co2f_pkg::OP_SPAN;
                args[0] = s_data.span_ppm[15:8];
                args[1] = s_data.span_ppm[7:0];
            end
            co2f_pkg::KIND_RANGE: begin
                opcode  = co2f_pkg::OP_RANGE;
                args[1] = s_data.range_word[31:24];
                args[2] = s_data.range_word[23:16];
                args[3] = s_data.range_word[15:8];
                args[4] = s_data.range_word[7:0];
            end
            co2f_pkg::KIND_AUTO: begin
                opcode  = co2f_pkg::OP_AUTO;
                args[0] = s_data.auto_on ? co2f_pkg::AUTO_ON_ARG : 8'h00;
            end
            default: opcode = co2f_pkg::OP_READ;
        endcase
    end

    assign body_sum   = addr_reg + opcode + args[0] + args[1] + args[2] + args[3] + args[4];
    assign expect_sum = 8'(-rx_sum_reg);

    always_comb begin
        q_push         = 1'b0;
        q_job          = '0;
        q_job.body[0]  = addr_reg;
        q_job.body[1]  = opcode;
        q_job.body[2]  = args[0];
        q_job.body[3]  = args[1];
        q_job.body[4]  = args[2];
        q_job.body[5]  = args[3];
        q_job.body[6]  = args[4];
        q_job.check    = 8'(-body_sum);
        rx_index_next  = rx_index_reg;
        rx_header_next = rx_header_reg;
        rx_high_next   = rx_high_reg;
        rx_low_next    = rx_low_reg;
        rx_sum_next    = rx_sum_reg;
        if (accept) begin
            unique case (s_data.kind) inside
                co2f_pkg::KIND_READ: begin
                    q_push        = 1'b1;
                    rx_index_next = '0;
                    rx_sum_next   = '0;
                end
                co2f_pkg::KIND_ZERO, co2f_pkg::KIND_SPAN,
                co2f_pkg::KIND_RANGE, co2f_pkg::KIND_AUTO: begin
                    q_push = 1'b1;
                end
                co2f_pkg::KIND_RX: begin
                    if (rx_index_reg == 4'd0) rx_header_next = s_data.rx_byte;
                    if (rx_index_reg == 4'd2) rx_high_next   = s_data.rx_byte;
                    if (rx_index_reg == 4'd3) rx_low_next    = s_data.rx_byte;
                    if (rx_index_reg != 4'd0 && !last_rx)
                        rx_sum_next = rx_sum_reg + s_data.rx_byte;
                    if (last_rx) begin
                        q_push           = 1'b1;
                        q_job.is_reading = 1'b1;
                        if (rx_header_reg != co2f_pkg::FRAME_START) begin
                            q_job.status = co2f_pkg::STATUS_BAD_HDR;
                        end else if (expect_sum != s_data.rx_byte) begin
                            q_job.status = co2f_pkg::STATUS_BAD_SUM;
                        end else begin
                            q_job.status = co2f_pkg::STATUS_OK;
                            q_job.ppm    = {rx_high_reg, rx_low_reg};
                        end
                        rx_index_next = '0;
                        rx_sum_next   = '0;
                    end else begin
                        rx_index_next = rx_index_reg + 4'd1;
                    end
                end
                default: q_push = 1'b0;  // unused kinds are dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= 8'd1;
            rx_index_reg  <= '0;
            rx_header_reg <= '0;
            rx_high_reg   <= '0;
            rx_low_reg    <= '0;
            rx_sum_reg    <= '0;
        end else begin
            if (cfg_valid) addr_reg <= cfg_data;
            rx_index_reg  <= rx_index_next;
            rx_header_reg <= rx_header_next;
            rx_high_reg   <= rx_high_next;
            rx_low_reg    <= rx_low_next;
            rx_sum_reg    <= rx_sum_next;
        end
    end

`ifndef SYNTHESIS
    a_rx_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_index_reg <= co2f_pkg::IDX_W'(co2f_pkg::FRAME_BYTES - 1))
        else $error("reply byte counter out of range");
    a_read_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.kind == co2f_pkg::KIND_READ |=> rx_index_reg == '0 && rx_sum_reg == '0)
        else $error("read request did not restart reply collection");
`endif

endmodule

FILE: design/co2f_queue.sv
// Short job queue between the front end and the frame serializer.
module co2f_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  co2f_pkg::job_t     push_job,
    output logic               full,
    input  logic               pop,
    output co2f_pkg::q_head_t  q_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    co2f_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full          = (count_reg == CNT_W'(DEPTH));
    assign q_head.empty  = (count_reg == '0);
    assign q_head.head   = mem_reg[rd_ptr_reg];
    assign do_push       = push && !full;
    assign do_pop        = pop && !q_head.empty;

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_head.empty))
        else $error("job popped from empty queue");
`endif

endmodule

FILE: design/co2f_back.sv
// Back end: serializes queued jobs into result transactions.
module co2f_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  co2f_pkg::q_head_t  q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output co2f_pkg::out_t     m_data
);

    logic [co2f_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;
    co2f_pkg::out_t             m_data_reg, m_data_next;
    logic                       load;
    logic                       last_byte;
    logic [2:0]                 body_idx;

    assign load      = !q_head.empty && (!m_valid_reg || m_ready);
    assign last_byte = (cnt_reg == co2f_pkg::IDX_W'(co2f_pkg::FRAME_BYTES - 1));
    assign body_idx  = 3'(cnt_reg - 4'd1);

    always_comb begin
        cnt_next     = cnt_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            if (q_head.head.is_reading) begin
                m_data_next.out_kind = co2f_pkg::OUT_READING;
                m_data_next.ppm      = q_head.head.ppm;
                m_data_next.status   = q_head.head.status;
                q_pop                = 1'b1;
            end else begin
                m_data_next.out_kind = co2f_pkg::OUT_TX;
                if (cnt_reg == '0)
                    m_data_next.tx_byte = co2f_pkg::FRAME_START;
                else if (last_byte)
                    m_data_next.tx_byte = q_head.head.check;
                else
                    m_data_next.tx_byte = q_head.head.body[body_idx];
                m_data_next.tx_last = last_byte;
                if (last_byte) begin
                    q_pop    = 1'b1;
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_frame_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 |-> !q_head.empty && !q_head.head.is_reading)
        else $error("frame in progress lost its queue entry");
`endif

endmodule

FILE: design/co2_sensor_uart_command_framer_core.sv
// Top level of the CO2 sensor UART command framer.
//
// Input channel s_*: one transaction per item. Command kinds (read, zero
// cal, span cal, set range, auto cal) each produce nine transmit-byte
// results, 0xFF first and the checksum last with tx_last set. A received
// byte item is folded into the reply being collected; the ninth reply byte
// produces one reading result with ppm and status. Unused kinds produce
// nothing.
// Output channel m_*: one transaction per result, in input order.
// cfg_*: writes the sensor address byte; always ready, write while idle.
// Path: an accepted input is written into the job queue and from there
// loaded into the output register. Throughput: one input per cycle into a
// QUEUE_DEPTH-entry job queue while it is not full; the output side gives
// one result per cycle while m_ready allows: nine per frame, one per reading.
// Reset clears the reply collector, the queue and the output valid flag and
// sets the address to 1. A stalled receiver fills the queue, after which
// s_ready drops until space frees up.
module co2_sensor_uart_command_framer_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  co2f_pkg::in_t        s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output co2f_pkg::out_t       m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    co2f_pkg::job_t     q_job;
    co2f_pkg::q_head_t  q_head;

    assign cfg_ready = 1'b1;

    co2f_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    co2f_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_head   (q_head)
    );

    co2f_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the CO2 sensor UART command framer core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 48;

    // ppm shaping for generated replies
    localparam int PPM_RANDOM = 0;
    localparam int PPM_ZERO   = 1;
    localparam int PPM_MAX    = 2;

    // Predicts the transmit frames and readings, then checks them in order.
    class frame_scoreboard;
        logic [7:0]     addr_byte;
        logic [3:0]     reply_count;
        logic [7:0]     reply_hdr;
        logic [7:0]     reply_hi;
        logic [7:0]     reply_lo;
        logic [7:0]     reply_sum;
        co2f_pkg::out_t results_due[$];
        int             errors;

        function new();
            addr_byte   = 8'h01;
            reply_count = '0;
            reply_hdr   = '0;
            reply_hi    = '0;
            reply_lo    = '0;
            reply_sum   = '0;
            errors      = 0;
        endfunction

        function void set_address(logic [7:0] value);
            addr_byte = value;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // args holds frame bytes 3..7, byte 3 in the top eight bits
        function void queue_frame(logic [7:0] opcode, logic [39:0] args);
            logic [7:0]     fb [co2f_pkg::FRAME_BYTES];
            logic [7:0]     sum;
            co2f_pkg::out_t r;
            fb[0] = co2f_pkg::FRAME_START;
            fb[1] = addr_byte;
            fb[2] = opcode;
            for (int i = 0; i < 5; i++) fb[3 + i] = args[39 - 8 * i -: 8];
            sum = '0;
            for (int i = 1; i < 8; i++) sum = sum + fb[i];
            fb[8] = 8'h00 - sum;
            for (int i = 0; i < co2f_pkg::FRAME_BYTES; i++) begin
                r.out_kind = co2f_pkg::OUT_TX;
                r.tx_byte  = fb[i];
                r.tx_last  = (i == co2f_pkg::FRAME_BYTES - 1);
                r.ppm      = '0;
                r.status   = co2f_pkg::STATUS_OK;
                results_due.push_back(r);
            end
        endfunction

        function void take_byte(logic [7:0] b);
            co2f_pkg::out_t r;
            if (reply_count == 0) reply_hdr = b;
            if (reply_count == 2) reply_hi = b;
            if (reply_count == 3) reply_lo = b;
            if (reply_count >= 1 && reply_count <= 7) reply_sum = reply_sum + b;
            if (reply_count < co2f_pkg::FRAME_BYTES - 1) begin
                reply_count = reply_count + 1;
                return;
            end
            r.out_kind = co2f_pkg::OUT_READING;
            r.tx_byte  = '0;
            r.tx_last  = 1'b0;
            r.ppm      = '0;
            if (reply_hdr != co2f_pkg::FRAME_START) begin
                r.status = co2f_pkg::STATUS_BAD_HDR;
            end else if (8'(8'h00 - reply_sum) != b) begin
                r.status = co2f_pkg::STATUS_BAD_SUM;
            end else begin
                r.status = co2f_pkg::STATUS_OK;
                r.ppm    = {reply_hi, reply_lo};
            end
            results_due.push_back(r);
            reply_count = '0;
            reply_sum   = '0;
        endfunction

        function void note_item(co2f_pkg::in_t it);
            case (it.kind)
                co2f_pkg::KIND_READ: begin
                    reply_count = '0;
                    reply_sum   = '0;
                    queue_frame(co2f_pkg::OP_READ, 40'h0);
                end
                co2f_pkg::KIND_ZERO:  queue_frame(co2f_pkg::OP_ZERO, 40'h0);
                co2f_pkg::KIND_SPAN:  queue_frame(co2f_pkg::OP_SPAN, {it.span_ppm, 24'h0});
                co2f_pkg::KIND_RANGE: queue_frame(co2f_pkg::OP_RANGE, {8'h00, it.range_word});
                co2f_pkg::KIND_AUTO:
                    queue_frame(co2f_pkg::OP_AUTO,
                                {(it.auto_on ? co2f_pkg::AUTO_ON_ARG : 8'h00), 32'h0});
                co2f_pkg::KIND_RX:    take_byte(it.rx_byte);
                default: ;
            endcase
        endfunction

        function void check_result(co2f_pkg::out_t got);
            co2f_pkg::out_t want;
            if (results_due.size() == 0) begin
                $error("unexpected result: out_kind %0d tx_byte %02h ppm %0d status %0d",
                       got.out_kind, got.tx_byte, got.ppm, got.status);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got.out_kind !== want.out_kind) begin
                $error("out_kind mismatch: expected %0d, actual %0d", want.out_kind, got.out_kind);
                errors++;
            end
            if (got.tx_byte !== want.tx_byte) begin
                $error("tx_byte mismatch: expected %02h, actual %02h", want.tx_byte, got.tx_byte);
                errors++;
            end
            if (got.tx_last !== want.tx_last) begin
                $error("tx_last mismatch: expected %0d, actual %0d", want.tx_last, got.tx_last);
                errors++;
            end
            if (got.ppm !== want.ppm) begin
                $error("ppm mismatch: expected %0d, actual %0d", want.ppm, got.ppm);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    co2f_pkg::in_t  s_data    = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    co2f_pkg::out_t m_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [7:0]     cfg_data  = '0;

    frame_scoreboard sb;
    int items_done = 0;
    int src_left   = 0;
    bit src_calm   = 1'b0;
    int sink_left  = 0;
    bit sink_calm  = 1'b0;
    int sink_hold  = 0;

    co2_sensor_uart_command_framer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Idle cycles per transaction; runs of zero-idle stretches come and go.
    function automatic int draw_wait(ref int left, ref bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(5, 30);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic co2f_pkg::in_t rand_item(logic [2:0] kind);
        co2f_pkg::in_t it;
        it.kind       = kind;
        it.span_ppm   = 16'($urandom);
        it.range_word = $urandom;
        it.auto_on    = 1'($urandom);
        it.rx_byte    = 8'($urandom);
        return it;
    endfunction

    // Result side: random back-pressure, check every accepted transaction.
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_hold <= 0;
        end else if (m_valid && m_ready) begin
            sb.check_result(m_data);
            n = draw_wait(sink_left, sink_calm);
            if (n == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready   <= 1'b0;
                sink_hold <= n - 1;
            end
        end else if (!m_ready) begin
            if (sink_hold == 0) m_ready <= 1'b1;
            else sink_hold <= sink_hold - 1;
        end
    end

    // Called at a rising edge; returns at the edge the transaction is accepted.
    task automatic send_item(co2f_pkg::in_t it);
        int gap;
        gap = draw_wait(src_left, src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        if (it.kind <= co2f_pkg::KIND_RX) items_done++;
    endtask

    task automatic send_rx(logic [7:0] b);
        co2f_pkg::in_t it;
        it = rand_item(co2f_pkg::KIND_RX);
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_cmd(logic [2:0] kind, logic [15:0] span, logic [31:0] range,
                            logic auto_on);
        co2f_pkg::in_t it;
        it = rand_item(kind);
        it.span_ppm   = span;
        it.range_word = range;
        it.auto_on    = auto_on;
        send_item(it);
    endtask

    // Sends the first count bytes of a sensor reply, optionally with a
    // non-read command slipped in partway through.
    task automatic send_reply(bit bad_hdr, bit bad_sum, int count, bit mid_cmd,
                              int ppm_mode);
        logic [7:0] b [co2f_pkg::FRAME_BYTES];
        logic [7:0] s;
        int         pos;
        b[0] = bad_hdr ? 8'($urandom_range(0, 254)) : co2f_pkg::FRAME_START;
        for (int i = 1; i < 8; i++) b[i] = 8'($urandom);
        if (ppm_mode == PPM_ZERO) begin
            b[2] = 8'h00;
            b[3] = 8'h00;
        end else if (ppm_mode == PPM_MAX) begin
            b[2] = 8'hFF;
            b[3] = 8'hFF;
        end
        s = '0;
        for (int i = 1; i < 8; i++) s = s + b[i];
        b[8] = 8'h00 - s;
        if (bad_sum) b[8] = b[8] ^ 8'($urandom_range(1, 255));
        pos = mid_cmd ? $urandom_range(1, 8) : co2f_pkg::FRAME_BYTES;
        for (int i = 0; i < count; i++) begin
            if (i == pos)
                send_item(rand_item(3'($urandom_range(co2f_pkg::KIND_ZERO,
                                                      co2f_pkg::KIND_AUTO))));
            send_rx(b[i]);
        end
    endtask

    // Wait until every expected result has arrived and the block has settled.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_address(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_address(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_cmd(co2f_pkg::KIND_READ, 16'h0, 32'h0, 1'b0);
        send_cmd(co2f_pkg::KIND_ZERO, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(co2f_pkg::KIND_SPAN, 16'h0000, 32'h0, 1'b0);
        send_cmd(co2f_pkg::KIND_SPAN, 16'hFFFF, 32'h0, 1'b0);
        send_cmd(co2f_pkg::KIND_RANGE, 16'h0, 32'h0000_0000, 1'b0);
        send_cmd(co2f_pkg::KIND_RANGE, 16'h0, 32'hFFFF_FFFF, 1'b0);
        send_cmd(co2f_pkg::KIND_AUTO, 16'h0, 32'h0, 1'b0);
        send_cmd(co2f_pkg::KIND_AUTO, 16'h0, 32'h0, 1'b1);
        send_item(rand_item(KIND_SPARE_LO));
        send_item(rand_item(KIND_SPARE_HI));
        // partial reply abandoned by a read request
        send_reply(1'b0, 1'b0, 3, 1'b0, PPM_RANDOM);
        send_cmd(co2f_pkg::KIND_READ, 16'h0, 32'h0, 1'b0);
        send_reply(1'b0, 1'b0, co2f_pkg::FRAME_BYTES, 1'b0, PPM_MAX);
    endtask

    function automatic int pick_ppm_mode();
        int m;
        m = $urandom_range(0, 11);
        if (m == 0) return PPM_ZERO;
        if (m == 1) return PPM_MAX;
        return PPM_RANDOM;
    endfunction

    task automatic run_random(int target);
        int r;
        int stop_at;
        stop_at = items_done + target;
        while (items_done < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if ($urandom_range(0, 9) < 7) send_item(rand_item(co2f_pkg::KIND_READ));
                send_reply($urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                           co2f_pkg::FRAME_BYTES, $urandom_range(0, 9) == 0, pick_ppm_mode());
            end else if (r < 65) begin
                send_item(rand_item(3'($urandom_range(co2f_pkg::KIND_READ,
                                                      co2f_pkg::KIND_AUTO))));
            end else if (r < 75) begin
                repeat ($urandom_range(1, 5)) send_rx(8'($urandom));
            end else if (r < 85) begin
                send_reply($urandom_range(0, 3) == 0, 1'b0, $urandom_range(1, 8), 1'b0,
                           pick_ppm_mode());
                send_item(rand_item(co2f_pkg::KIND_READ));
            end else if (r < 90) begin
                send_item(rand_item(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))));
            end else begin
                // header and checksum both wrong
                send_item(rand_item(co2f_pkg::KIND_READ));
                send_reply(1'b1, 1'b1, co2f_pkg::FRAME_BYTES, 1'b0, pick_ppm_mode());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        drain();
        write_address(8'h00);
        run_random(75);
        drain();
        write_address(8'hFF);
        run_random(75);
        drain();
        write_address(8'($urandom));
        run_random(75);
        drain();
        write_address(8'($urandom));
        run_random(75);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
